FILE: design/swm_pkg.sv
// Shared types and constants for the sliding window median filter.
// No dependencies; imported by the cell, the top level and the checker.
`default_nettype none

package swm_pkg;

    // Default build sizes.
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Width of the window size register and its value after reset.
    localparam int CFG_BITS     = 7;
    localparam int WINDOW_RESET = 3;

    // Operation broadcast to every sorted cell in a cycle.
    typedef struct packed {
        logic del;  // close the gap left by the oldest sample
        logic ins;  // open a slot and drop the new sample into it
    } t_cell_op;

endpackage

`default_nettype wire

FILE: design/swm_cell.sv
// One cell of the sorted window: holds one sample and trades it with its neighbors.
// Depends on swm_pkg for the broadcast operation type.
`default_nettype none

module swm_cell
    import swm_pkg::*;
#(
    parameter int INDEX       = 0,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int CW          = 7
) (
    input  wire logic                          i_clk,
    input  wire t_cell_op                      i_op,
    input  wire logic signed [SAMPLE_BITS-1:0] i_key,
    input  wire logic        [CW-1:0]          i_count,
    input  wire logic signed [SAMPLE_BITS-1:0] i_left_val,
    input  wire logic                          i_left_gt,
    input  wire logic signed [SAMPLE_BITS-1:0] i_right_val,
    output logic signed      [SAMPLE_BITS-1:0] o_val,
    output logic                               o_gt
);

    logic signed [SAMPLE_BITS-1:0] r_val;
    logic signed [SAMPLE_BITS-1:0] n_val;
    logic                          in_use;
    logic                          at_end;
    logic                          ge_key;

    // The cell is part of the occupied list when its place is below the count.
    assign in_use = (CW'(INDEX) < i_count);
    assign at_end = (CW'(INDEX) == i_count);
    assign ge_key = (r_val >= i_key);
    assign o_gt   = in_use && (r_val > i_key);

    // Because the list is sorted, every cell at or above the first match
    // of the leaving sample holds a value no smaller than it.
    always_comb begin
        n_val = r_val;
        if (i_op.del) begin
            if (ge_key) begin
                n_val = i_right_val;
            end
        end else if (i_op.ins) begin
            if (i_left_gt) begin
                n_val = i_left_val;
            end else if (o_gt || at_end) begin
                n_val = i_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

FILE: design/sliding_window_median.sv
// Top level of the sliding window median filter: control, arrival ring and cell row.
// Depends on swm_pkg and swm_cell.
//
// Channel   | Direction | Payload
// ----------+-----------+---------------------------------------------------
// s_axis    | in        | tdata: sample; tuser: start_new
// m_axis    | out       | tdata: median_doubled (zero padded to bytes)
// cfg_wr    | in        | wr_data: window_size, written whenever wr_en is high
//
// A sample in a full window goes through the ring read, a delete and an
// insert, and then the middle cells are read into the output register. While
// the window is still filling a sample skips the delete, and only the sample
// that fills it goes on to read the middle cells. The cell row does one delete
// or insert per cycle. Reset is synchronous and clears the control state and
// the output valid; the ring and the cells hold data only. A stalled output
// keeps its result and blocks the median cycle of the next sample; the input
// is taken while a result still waits.
`default_nettype none

module sliding_window_median
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((SAMPLE_BITS + 1 + 7) / 8) * 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Configuration write.
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_BITS-1:0]    i_cfg_wr_data,   // window_size
    // Input stream.
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [SAMPLE_BITS-1:0] sample
    input  wire logic                   i_s_axis_tuser,  // [0] start_new
    // Output stream.
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata   // [SAMPLE_BITS:0] median_doubled
);

    localparam int CW      = $clog2(WINDOW_MAX + 1);
    localparam int AW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int K_RESET = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEL,
        S_INS,
        S_MED
    } t_state;

    t_state r_state;

    // Control registers.
    logic        [CW-1:0]          r_k;
    logic        [CW-1:0]          r_fill;
    logic        [AW-1:0]          r_ptr;
    logic        [CW-1:0]          r_n_ins;
    logic                          r_emit;
    logic                          r_full;
    logic signed [SAMPLE_BITS-1:0] r_key;
    logic signed [SAMPLE_BITS-1:0] r_old;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS:0]   r_med;

    // Arrival ring.
    logic signed [SAMPLE_BITS-1:0] r_ring [WINDOW_MAX];

    // Cell row wiring.
    logic signed [SAMPLE_BITS-1:0] cell_val   [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] cell_left  [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] cell_right [WINDOW_MAX];
    logic                          cell_gt    [WINDOW_MAX];
    logic                          cell_lgt   [WINDOW_MAX];
    t_cell_op                      cell_op;
    logic signed [SAMPLE_BITS-1:0] cell_key;

    logic                          in_xact;
    logic                          out_xact;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic        [CW-1:0]          fill_eff;
    logic        [AW-1:0]          ptr_eff;
    logic        [CW-1:0]          ptr_inc;
    logic                          win_full;
    logic        [31:0]            k_cfg;
    logic        [CW-1:0]          mid_hi;
    logic        [CW-1:0]          mid_lo;
    logic signed [SAMPLE_BITS:0]   med_sum;
    logic                          out_free;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xact         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xact        = r_out_valid && i_m_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign in_sample       = $signed(i_s_axis_tdata[SAMPLE_BITS-1:0]);

    // A restart empties the window before the new sample enters.
    assign fill_eff = i_s_axis_tuser ? '0 : r_fill;
    assign ptr_eff  = i_s_axis_tuser ? '0 : r_ptr;
    assign win_full = (fill_eff == r_k);
    assign ptr_inc  = CW'(ptr_eff) + CW'(1);

    // Window size clamped to the built range.
    always_comb begin
        k_cfg = 32'(i_cfg_wr_data);
        if (k_cfg == 32'd0) begin
            k_cfg = 32'd1;
        end else if (k_cfg > 32'(WINDOW_MAX)) begin
            k_cfg = 32'(WINDOW_MAX);
        end
    end

    // Middle cells: one for an odd window, the two around the center otherwise.
    assign mid_hi  = r_k >> 1;
    assign mid_lo  = r_k[0] ? mid_hi : (mid_hi - CW'(1));
    assign med_sum = {cell_val[mid_lo[AW-1:0]][SAMPLE_BITS-1], cell_val[mid_lo[AW-1:0]]}
                   + {cell_val[mid_hi[AW-1:0]][SAMPLE_BITS-1], cell_val[mid_hi[AW-1:0]]};

    // Arrival ring: the oldest sample is read as the new one overwrites it.
    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_old            <= r_ring[ptr_eff];
            r_ring[ptr_eff]  <= in_sample;
        end
    end

    // Sequencer, window bookkeeping and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= CW'(K_RESET);
            r_fill      <= '0;
            r_ptr       <= '0;
            r_n_ins     <= '0;
            r_emit      <= 1'b0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The result is loaded at the end of the median cycle and cleared when taken.
            if ((r_state == S_MED) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_xact) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_k <= CW'(k_cfg);
            end
            // Fill level and ring slot advance per sample; a size write with no sample taken empties the window.
            if (in_xact) begin
                r_fill <= win_full ? fill_eff : (fill_eff + CW'(1));
                r_ptr  <= (ptr_inc == r_k) ? '0 : ptr_inc[AW-1:0];
            end else if (i_cfg_wr_en) begin
                r_fill <= '0;
                r_ptr  <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xact) begin
                        r_key   <= in_sample;
                        r_full  <= win_full;
                        r_n_ins <= win_full ? (r_k - CW'(1)) : fill_eff;
                        r_emit  <= win_full || ((fill_eff + CW'(1)) == r_k);
                        r_state <= win_full ? S_DEL : S_INS;
                    end
                end
                S_DEL: begin
                    r_state <= S_INS;
                end
                S_INS: begin
                    r_state <= r_emit ? S_MED : S_IDLE;
                end
                S_MED: begin
                    if (out_free) begin
                        r_med   <= med_sum;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Broadcast to the cell row.
    assign cell_op.del = (r_state == S_DEL);
    assign cell_op.ins = (r_state == S_INS);
    assign cell_key    = (r_state == S_DEL) ? r_old : r_key;

    // Row of sorted cells, each linked to its two neighbors.
    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        if (g == 0) begin : g_left_edge
            assign cell_left[g] = cell_val[g];
            assign cell_lgt[g]  = 1'b0;
        end else begin : g_left_link
            assign cell_left[g] = cell_val[g-1];
            assign cell_lgt[g]  = cell_gt[g-1];
        end
        if (g == WINDOW_MAX - 1) begin : g_right_edge
            assign cell_right[g] = cell_val[g];
        end else begin : g_right_link
            assign cell_right[g] = cell_val[g+1];
        end

        swm_cell #(
            .INDEX       (g),
            .SAMPLE_BITS (SAMPLE_BITS),
            .CW          (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (cell_op),
            .i_key       (cell_key),
            .i_count     (r_n_ins),
            .i_left_val  (cell_left[g]),
            .i_left_gt   (cell_lgt[g]),
            .i_right_val (cell_right[g]),
            .o_val       (cell_val[g]),
            .o_gt        (cell_gt[g])
        );
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'($unsigned(r_med));

endmodule

`default_nettype wire

FILE: design/swm_checker.sv
// Port-level checks for the sliding window median filter, bound to the top level.
// Depends on swm_pkg for the default sample width.
`default_nettype none

module swm_checker
    import swm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int OUT_TDATA_W = ((SAMPLE_BITS + 1 + 7) / 8) * 8
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_axis_tvalid,
    input wire logic                   o_s_axis_tready,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output transaction changed or dropped");

    // After reset the block is ready and has no result pending.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready && !o_m_axis_tvalid)
        else $error("block not clean after reset");

    // One sample is worked on at a time: the input closes after a transaction.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted while a sample is in progress");

    // A result needs at least the delete or insert cycle after the input transaction.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !$rose(o_m_axis_tvalid))
        else $error("result appeared too soon after input transaction");

endmodule

bind sliding_window_median swm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
